// File: rtl/core/gdcc_pkg.sv
`default_nettype none

package gdcc_pkg;

  // default parameter values
  localparam int CMD_FRAC_BITS_DEF = 14;
  localparam int TIME_BITS_DEF     = 32;

  // configuration port
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DEADBAND     = 3'd0,
    REG_DISC_TIMEOUT = 3'd1,
    REG_HOLD         = 3'd2,
    REG_SPD_DEFAULT  = 3'd3,
    REG_SPD_SLOW     = 3'd4,
    REG_SPD_MEDIUM   = 3'd5,
    REG_SPD_FAST     = 3'd6
  } reg_idx_e;

  localparam logic [15:0] DEADBAND_RST     = 16'd6554;
  localparam logic [15:0] DISC_TIMEOUT_RST = 16'd100;
  localparam logic [15:0] HOLD_RST         = 16'd1000;
  localparam logic [15:0] SPD_DEFAULT_RST  = 16'd39322;
  localparam logic [15:0] SPD_SLOW_RST     = 16'd16384;
  localparam logic [15:0] SPD_MEDIUM_RST   = 16'd32768;
  localparam logic [15:0] SPD_FAST_RST     = 16'd65535;

  // button bit positions in the pad word
  localparam int BTN_SELECT   = 0;
  localparam int BTN_START    = 3;
  localparam int BTN_UP       = 4;
  localparam int BTN_RIGHT    = 5;
  localparam int BTN_DOWN     = 6;
  localparam int BTN_LEFT     = 7;
  localparam int BTN_L2       = 8;
  localparam int BTN_L1       = 10;
  localparam int BTN_R1       = 11;
  localparam int BTN_TRIANGLE = 12;

  // quotient bits per axis, step counter width
  localparam int QUOT_STEPS = 31;
  localparam int STEP_CNT_W = 5;

  typedef enum logic [1:0] {
    SPD_DEFAULT = 2'd0,
    SPD_SLOW    = 2'd1,
    SPD_MEDIUM  = 2'd2,
    SPD_FAST    = 2'd3
  } speed_e;

  typedef enum logic [1:0] {
    AXIS_FWD  = 2'd0,
    AXIS_LAT  = 2'd1,
    AXIS_TURN = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_SETUP   = 3'd1,
    ST_DIV     = 3'd2,
    ST_SQUARE  = 3'd3,
    ST_ROUND   = 3'd4,
    ST_PUBLISH = 3'd5
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  setup;
    logic  div_step;
    logic  div_first;
    logic  square;
    logic  store;
    logic  publish;
    axis_e axis;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ok;
    logic dead;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/gdcc_ctrl.sv
`default_nettype none

module gdcc_ctrl (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output logic                     in_ready_o,
  input  wire gdcc_pkg::status_t   status_i,
  output gdcc_pkg::cmd_t           cmd_o
);

  gdcc_pkg::state_e state_q, state_d;
  gdcc_pkg::axis_e  axis_q, axis_d;
  logic [gdcc_pkg::STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic last_step;

  assign last_step = (cnt_q == gdcc_pkg::STEP_CNT_W'(gdcc_pkg::QUOT_STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gdcc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = gdcc_pkg::ST_SETUP;
      end
      gdcc_pkg::ST_SETUP: begin
        if (!status_i.ok) state_d = gdcc_pkg::ST_PUBLISH;
        else if (status_i.dead) state_d = gdcc_pkg::ST_ROUND;
        else state_d = gdcc_pkg::ST_DIV;
      end
      gdcc_pkg::ST_DIV: begin
        if (last_step) state_d = gdcc_pkg::ST_SQUARE;
      end
      gdcc_pkg::ST_SQUARE: begin
        state_d = gdcc_pkg::ST_ROUND;
      end
      gdcc_pkg::ST_ROUND: begin
        if (axis_q == gdcc_pkg::AXIS_TURN) state_d = gdcc_pkg::ST_PUBLISH;
        else state_d = gdcc_pkg::ST_SETUP;
      end
      gdcc_pkg::ST_PUBLISH: begin
        if (status_i.out_free) state_d = gdcc_pkg::ST_IDLE;
      end
      default: state_d = gdcc_pkg::ST_IDLE;
    endcase
  end

  // axis and step counter updates
  always_comb begin
    axis_d = axis_q;
    cnt_d  = '0;
    case (state_q)
      gdcc_pkg::ST_IDLE: axis_d = gdcc_pkg::AXIS_FWD;
      gdcc_pkg::ST_DIV: begin
        if (!last_step) cnt_d = cnt_q + 1'b1;
      end
      gdcc_pkg::ST_ROUND: begin
        case (axis_q)
          gdcc_pkg::AXIS_FWD: axis_d = gdcc_pkg::AXIS_LAT;
          gdcc_pkg::AXIS_LAT: axis_d = gdcc_pkg::AXIS_TURN;
          default:            axis_d = gdcc_pkg::AXIS_FWD;
        endcase
      end
      default: axis_d = axis_q;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    in_ready_o = 1'b0;
    case (state_q)
      gdcc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      gdcc_pkg::ST_SETUP:  cmd_o.setup = 1'b1;
      gdcc_pkg::ST_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == '0);
      end
      gdcc_pkg::ST_SQUARE: cmd_o.square = 1'b1;
      gdcc_pkg::ST_ROUND:  cmd_o.store = 1'b1;
      gdcc_pkg::ST_PUBLISH: cmd_o.publish = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdcc_pkg::ST_IDLE;
      axis_q  <= gdcc_pkg::AXIS_FWD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gdcc_dpath.sv
`default_nettype none

module gdcc_dpath #(
  parameter int CMD_FRAC_BITS = gdcc_pkg::CMD_FRAC_BITS_DEF,
  parameter int TIME_BITS     = gdcc_pkg::TIME_BITS_DEF
) (
  input  wire                   logic clk_i,
  input  wire                   logic rst_ni,
  input  wire gdcc_pkg::cmd_t         cmd_i,
  output gdcc_pkg::status_t           status_o,
  // configuration
  input  wire                   logic cfg_valid_i,
  input  wire [gdcc_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  wire                   logic [15:0] cfg_data_i,
  // input word
  input  wire                   logic        read_ok_i,
  input  wire                   logic [15:0] button_word_i,
  input  wire                   logic [7:0]  left_stick_x_i,
  input  wire                   logic [7:0]  left_stick_y_i,
  input  wire                   logic [7:0]  right_stick_x_i,
  input  wire                   logic [31:0] now_ms_i,
  // result word
  input  wire                   logic        out_ready_i,
  output logic                               out_valid_o,
  output logic                               fresh_o,
  output logic                               connected_o,
  output logic                               estop_active_o,
  output logic                               estop_clearing_o,
  output logic signed [15:0]                 forward_cmd_o,
  output logic signed [15:0]                 lateral_cmd_o,
  output logic signed [15:0]                 turn_cmd_o,
  output logic        [15:0]                 speed_scale_o,
  output logic                               motor_active_o,
  output logic        [15:0]                 pressed_mask_o,
  output logic        [15:0]                 released_mask_o
);

  localparam int RND_POS   = 59 - CMD_FRAC_BITS;
  localparam int SHIFT_AMT = 60 - CMD_FRAC_BITS;
  localparam int MAG_W     = CMD_FRAC_BITS + 1;
  localparam int ONE_INT   = (CMD_FRAC_BITS > 14) ? 32767 : (1 << CMD_FRAC_BITS);
  localparam logic signed [15:0] CMD_ONE = 16'(ONE_INT);

  // configuration registers
  logic [15:0] deadband_q, timeout_q, hold_q;
  logic [15:0] spd_def_q, spd_slow_q, spd_med_q, spd_fast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= gdcc_pkg::DEADBAND_RST;
      timeout_q  <= gdcc_pkg::DISC_TIMEOUT_RST;
      hold_q     <= gdcc_pkg::HOLD_RST;
      spd_def_q  <= gdcc_pkg::SPD_DEFAULT_RST;
      spd_slow_q <= gdcc_pkg::SPD_SLOW_RST;
      spd_med_q  <= gdcc_pkg::SPD_MEDIUM_RST;
      spd_fast_q <= gdcc_pkg::SPD_FAST_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gdcc_pkg::REG_DEADBAND:     deadband_q <= cfg_data_i;
        gdcc_pkg::REG_DISC_TIMEOUT: timeout_q  <= cfg_data_i;
        gdcc_pkg::REG_HOLD:         hold_q     <= cfg_data_i;
        gdcc_pkg::REG_SPD_DEFAULT:  spd_def_q  <= cfg_data_i;
        gdcc_pkg::REG_SPD_SLOW:     spd_slow_q <= cfg_data_i;
        gdcc_pkg::REG_SPD_MEDIUM:   spd_med_q  <= cfg_data_i;
        gdcc_pkg::REG_SPD_FAST:     spd_fast_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched stick bytes and read flag
  logic       ok_q;
  logic [7:0] lx_q, ly_q, rx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (cmd_i.load) begin
      ok_q <= read_ok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lx_q <= left_stick_x_i;
      ly_q <= left_stick_y_i;
      rx_q <= right_stick_x_i;
    end
  end

  // timestamp, low TIME_BITS bits of the poll time
  logic [63:0]          now_ext;
  logic [TIME_BITS-1:0] now_t;
  assign now_ext = {32'd0, now_ms_i};
  assign now_t   = now_ext[TIME_BITS-1:0];

  // link, stop machine, button history and speed choice
  logic                 link_q, link_d;
  logic [TIME_BITS-1:0] last_good_q, last_good_d;
  logic                 stop_q, stop_d;
  logic                 pend_q, pend_d;
  logic [TIME_BITS-1:0] begin_q, begin_d;
  logic [15:0]          btn_now_q, btn_now_d, btn_prev_q, btn_prev_d;
  gdcc_pkg::speed_e     speed_q, speed_d;

  logic [TIME_BITS-1:0] since_good, since_hold;
  logic                 sel_start, start_tri;

  assign since_good = now_t - last_good_q;
  assign since_hold = now_t - begin_q;
  assign sel_start  = button_word_i[gdcc_pkg::BTN_SELECT] & button_word_i[gdcc_pkg::BTN_START];
  assign start_tri  = button_word_i[gdcc_pkg::BTN_START] &
                      button_word_i[gdcc_pkg::BTN_TRIANGLE];

  always_comb begin
    link_d      = link_q;
    last_good_d = last_good_q;
    stop_d      = stop_q;
    pend_d      = pend_q;
    begin_d     = begin_q;
    btn_now_d   = btn_now_q;
    btn_prev_d  = btn_prev_q;
    speed_d     = speed_q;
    if (cmd_i.load) begin
      if (read_ok_i) begin
        link_d      = 1'b1;
        last_good_d = now_t;
        btn_prev_d  = btn_now_q;
        btn_now_d   = button_word_i;
        if (stop_q && sel_start) begin
          // clear hold in progress
          if (!pend_q) begin
            pend_d  = 1'b1;
            begin_d = now_t;
          end else if (since_hold > TIME_BITS'(hold_q)) begin
            stop_d = 1'b0;
            pend_d = 1'b0;
          end
        end else begin
          pend_d = 1'b0;
          if (!stop_q && start_tri) begin
            stop_d = 1'b1;
          end else if (!stop_q) begin
            if (button_word_i[gdcc_pkg::BTN_L1]) speed_d = gdcc_pkg::SPD_SLOW;
            else if (button_word_i[gdcc_pkg::BTN_R1]) speed_d = gdcc_pkg::SPD_FAST;
            else if (button_word_i[gdcc_pkg::BTN_L2]) speed_d = gdcc_pkg::SPD_MEDIUM;
            else speed_d = gdcc_pkg::SPD_DEFAULT;
          end
        end
      end else if (since_good > TIME_BITS'(timeout_q) && link_q) begin
        // link timeout drops the link and latches stop
        link_d = 1'b0;
        stop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q      <= 1'b0;
      last_good_q <= '0;
      stop_q      <= 1'b0;
      pend_q      <= 1'b0;
      begin_q     <= '0;
      btn_now_q   <= '0;
      btn_prev_q  <= '0;
      speed_q     <= gdcc_pkg::SPD_DEFAULT;
    end else begin
      link_q      <= link_d;
      last_good_q <= last_good_d;
      stop_q      <= stop_d;
      pend_q      <= pend_d;
      begin_q     <= begin_d;
      btn_now_q   <= btn_now_d;
      btn_prev_q  <= btn_prev_d;
      speed_q     <= speed_d;
    end
  end

  // axis setup: centre, deadband, numerator and denominator
  logic [7:0]  raw, mag_a, div_v;
  logic        invert, raw_pos, neg;
  logic [23:0] a_sh, dv, num;
  logic [16:0] span;
  logic [24:0] den_w;
  logic        dead;

  always_comb begin
    case (cmd_i.axis)
      gdcc_pkg::AXIS_FWD: begin
        raw    = ly_q;
        invert = 1'b1;
      end
      gdcc_pkg::AXIS_LAT: begin
        raw    = rx_q;
        invert = 1'b0;
      end
      default: begin
        raw    = lx_q;
        invert = 1'b0;
      end
    endcase
  end

  assign raw_pos = raw[7];
  assign mag_a   = raw_pos ? {1'b0, raw[6:0]} : (8'd128 - raw);
  assign div_v   = raw_pos ? 8'd127 : 8'd128;
  assign neg     = (!raw_pos) ^ invert;
  assign a_sh    = {mag_a, 16'd0};
  assign dv      = 24'(deadband_q) * 24'(div_v);
  assign span    = 17'h10000 - {1'b0, deadband_q};
  assign den_w   = 25'(span) * 25'(div_v);
  assign dead    = (a_sh < dv);
  assign num     = a_sh - dv;

  // shared restoring divider and squarer
  logic        neg_q, dead_q;
  logic [24:0] rem_q, rem_t;
  logic [23:0] den_q;
  logic [30:0] quot_q;
  logic [61:0] sq_q;
  logic        ge;

  assign rem_t = cmd_i.div_first ? rem_q : {rem_q[23:0], 1'b0};
  assign ge    = (rem_t >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      neg_q  <= neg;
      dead_q <= dead;
      rem_q  <= {1'b0, num};
      den_q  <= den_w[23:0];
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? (rem_t - {1'b0, den_q}) : rem_t;
      quot_q <= {quot_q[29:0], ge};
    end
    if (cmd_i.square) begin
      sq_q <= 62'(quot_q) * 62'(quot_q);
    end
  end

  // round half up, saturate, sign, d-pad override
  logic [62:0]        rnd_sum;
  logic [MAG_W-1:0]   mag;
  logic [31:0]        mag32;
  logic [14:0]        mag15;
  logic signed [15:0] axis_val, store_val;

  assign rnd_sum = 63'(sq_q) + (63'd1 << RND_POS);
  assign mag     = rnd_sum[SHIFT_AMT +: MAG_W];
  assign mag32   = 32'(mag);
  assign mag15   = (mag32 > 32'd32767) ? 15'h7fff : mag32[14:0];

  always_comb begin
    if (dead_q) axis_val = '0;
    else if (neg_q) axis_val = -$signed({1'b0, mag15});
    else axis_val = $signed({1'b0, mag15});
    store_val = axis_val;
    case (cmd_i.axis)
      gdcc_pkg::AXIS_FWD: begin
        if (btn_now_q[gdcc_pkg::BTN_UP]) store_val = CMD_ONE;
        else if (btn_now_q[gdcc_pkg::BTN_DOWN]) store_val = -CMD_ONE;
      end
      gdcc_pkg::AXIS_TURN: begin
        if (btn_now_q[gdcc_pkg::BTN_LEFT]) store_val = -CMD_ONE;
        else if (btn_now_q[gdcc_pkg::BTN_RIGHT]) store_val = CMD_ONE;
      end
      default: store_val = axis_val;
    endcase
  end

  logic signed [15:0] fwd_q, lat_q, turn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= '0;
      lat_q  <= '0;
      turn_q <= '0;
    end else if (cmd_i.store) begin
      case (cmd_i.axis)
        gdcc_pkg::AXIS_FWD: fwd_q  <= store_val;
        gdcc_pkg::AXIS_LAT: lat_q  <= store_val;
        default:            turn_q <= store_val;
      endcase
    end
  end

  // motion threshold: magnitude times 50 above one
  function automatic logic over_eps(input logic signed [15:0] val);
    logic [15:0] m;
    logic [31:0] prod;
    m    = val[15] ? 16'(-val) : val;
    prod = 32'(m) * 32'd50;
    return prod > (32'd1 << CMD_FRAC_BITS);
  endfunction

  logic [15:0] scale_sel;

  always_comb begin
    case (speed_q)
      gdcc_pkg::SPD_SLOW:   scale_sel = spd_slow_q;
      gdcc_pkg::SPD_MEDIUM: scale_sel = spd_med_q;
      gdcc_pkg::SPD_FAST:   scale_sel = spd_fast_q;
      default:              scale_sel = spd_def_q;
    endcase
  end

  // result word register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      fresh_o          <= ok_q;
      connected_o      <= link_q;
      estop_active_o   <= stop_q;
      estop_clearing_o <= pend_q;
      forward_cmd_o    <= fwd_q;
      lateral_cmd_o    <= lat_q;
      turn_cmd_o       <= turn_q;
      speed_scale_o    <= scale_sel;
      motor_active_o   <= over_eps(fwd_q) | over_eps(lat_q) | over_eps(turn_q);
      pressed_mask_o   <= btn_now_q & ~btn_prev_q;
      released_mask_o  <= btn_prev_q & ~btn_now_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.ok       = ok_q;
  assign status_o.dead     = dead;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// File: rtl/core/gamepad_drive_command_conditioner_top.sv
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    read_ok_i .. now_ms_i
// out       output     out_valid_o / out_ready_i  fresh_o .. released_mask_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// a good read is accepted, then each axis gets a setup, 31 restoring-divider
// steps, a square and a round, and the word is then published; a deadbanded
// axis skips the divider and square. a failed read goes from setup to publish.
// the single shared divider sets the rate; one word is worked on at a time.
// reset restores the register defaults and clears link, stop and commands.
// a result held by out_ready_i low stalls the next word only at its publish.
`default_nettype none

module gamepad_drive_command_conditioner_top #(
  parameter int CMD_FRAC_BITS = gdcc_pkg::CMD_FRAC_BITS_DEF,
  parameter int TIME_BITS     = gdcc_pkg::TIME_BITS_DEF
) (
  input  wire  logic                          clk_i,
  input  wire  logic                          rst_ni,
  // configuration
  input  wire  logic                          cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  logic [gdcc_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  wire  logic [15:0]                   cfg_data_i,
  // input word
  input  wire  logic                          in_valid_i,
  output logic                                in_ready_o,
  input  wire  logic                          read_ok_i,
  input  wire  logic [15:0]                   button_word_i,
  input  wire  logic [7:0]                    left_stick_x_i,
  input  wire  logic [7:0]                    left_stick_y_i,
  input  wire  logic [7:0]                    right_stick_x_i,
  input  wire  logic [31:0]                   now_ms_i,
  // result word
  output logic                                out_valid_o,
  input  wire  logic                          out_ready_i,
  output logic                                fresh_o,
  output logic                                connected_o,
  output logic                                estop_active_o,
  output logic                                estop_clearing_o,
  output logic signed [15:0]                  forward_cmd_o,
  output logic signed [15:0]                  lateral_cmd_o,
  output logic signed [15:0]                  turn_cmd_o,
  output logic        [15:0]                  speed_scale_o,
  output logic                                motor_active_o,
  output logic        [15:0]                  pressed_mask_o,
  output logic        [15:0]                  released_mask_o
);

  gdcc_pkg::cmd_t    cmd;
  gdcc_pkg::status_t status;

  // registers always take a write
  assign cfg_ready_o = 1'b1;

  // sequencer
  gdcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  gdcc_dpath #(
    .CMD_FRAC_BITS (CMD_FRAC_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .read_ok_i        (read_ok_i),
    .button_word_i    (button_word_i),
    .left_stick_x_i   (left_stick_x_i),
    .left_stick_y_i   (left_stick_y_i),
    .right_stick_x_i  (right_stick_x_i),
    .now_ms_i         (now_ms_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .fresh_o          (fresh_o),
    .connected_o      (connected_o),
    .estop_active_o   (estop_active_o),
    .estop_clearing_o (estop_clearing_o),
    .forward_cmd_o    (forward_cmd_o),
    .lateral_cmd_o    (lateral_cmd_o),
    .turn_cmd_o       (turn_cmd_o),
    .speed_scale_o    (speed_scale_o),
    .motor_active_o   (motor_active_o),
    .pressed_mask_o   (pressed_mask_o),
    .released_mask_o  (released_mask_o)
  );

`ifndef NO_ASSERTIONS
  // an accepted word closes the input side, so no second word is taken back to back
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted back to back");

  // a publish never overwrites a result still waiting
  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten before it was taken");

  // a result appears only after a publish
  a_valid_from_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.publish))
    else $error("result valid without publish");

  // the divider never runs while the input side is open
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_step || cmd.square || cmd.store) |-> !in_ready_o)
    else $error("arithmetic active while idle");
`endif

endmodule

`default_nettype wire

// File: verif/drive_report_checker.sv
`default_nettype none

module drive_report_checker
  import gdcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [REG_IDX_W-1:0]  cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_o,
  input  logic                  read_ok_i,
  input  logic [15:0]           button_word_i,
  input  logic [7:0]            left_stick_x_i,
  input  logic [7:0]            left_stick_y_i,
  input  logic [7:0]            right_stick_x_i,
  input  logic [31:0]           now_ms_i,
  input  logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic                  fresh_o,
  input  logic                  connected_o,
  input  logic                  estop_active_o,
  input  logic                  estop_clearing_o,
  input  logic signed [15:0]    forward_cmd_o,
  input  logic signed [15:0]    lateral_cmd_o,
  input  logic signed [15:0]    turn_cmd_o,
  input  logic [15:0]           speed_scale_o,
  input  logic                  motor_active_o,
  input  logic [15:0]           pressed_mask_o,
  input  logic [15:0]           released_mask_o,
  output int                    mismatch_count_o,
  output int                    pending_reports_o
);

  localparam int CMD_ONE = 1 << CMD_FRAC_BITS_DEF;

  typedef struct packed {
    logic               fresh;
    logic               connected;
    logic               estop_active;
    logic               estop_clearing;
    logic signed [15:0] forward_cmd;
    logic signed [15:0] lateral_cmd;
    logic signed [15:0] turn_cmd;
    logic [15:0]        speed_scale;
    logic               motor_active;
    logic [15:0]        pressed_mask;
    logic [15:0]        released_mask;
  } drive_report_t;

  // shadow of the register file and the conditioner state
  logic [15:0]        cfg_regs [7];
  logic               link_up;
  logic               stop_latched;
  logic               clear_pending;
  logic [31:0]        last_good_ms;
  logic [31:0]        clear_begin_ms;
  logic [15:0]        pad_now;
  logic [15:0]        pad_prev;
  logic signed [15:0] fwd_cmd;
  logic signed [15:0] lat_cmd;
  logic signed [15:0] trn_cmd;
  speed_e             speed_sel;

  drive_report_t      reports_due [$];
  int                 err_count;

  function automatic logic signed [15:0] sat_cmd(input int x);
    if (x > 32767) return 16'sd32767;
    if (x < -32767) return -16'sd32767;
    return x[15:0];
  endfunction

  // centre, deadband, rescale to 2^30, square with rounding, restore sign
  function automatic logic signed [15:0] stick_cmd(input logic [7:0] raw, input logic invert);
    int                c;
    longint unsigned   a, v, d, n, den, s, mag;
    logic              neg;
    c = int'(raw) - 128;
    if (c < 0) a = -c;
    else a = c;
    v = (c >= 0) ? 127 : 128;
    d = cfg_regs[REG_DEADBAND];
    neg = (c < 0) != invert;
    if (a * 65536 < d * v) return '0;
    n = a * 65536 - d * v;
    den = v * (65536 - d);
    s = (n << 30) / den;
    mag = (s * s + (64'd1 << (59 - CMD_FRAC_BITS_DEF))) >> (60 - CMD_FRAC_BITS_DEF);
    return sat_cmd(neg ? -int'(mag) : int'(mag));
  endfunction

  function automatic logic above_creep(input logic signed [15:0] cmd);
    int m;
    m = cmd;
    if (m < 0) m = -m;
    return (m * 50) > CMD_ONE;
  endfunction

  // advance the shadow state by one poll and build the report it yields
  function automatic drive_report_t condition_poll();
    drive_report_t r;
    logic [31:0]   elapsed;
    logic [15:0]   b;
    b = button_word_i;
    if (read_ok_i) begin
      link_up = 1'b1;
      last_good_ms = now_ms_i;
      pad_prev = pad_now;
      pad_now = b;
      if (stop_latched && b[BTN_SELECT] && b[BTN_START]) begin
        // clear hold: first read arms it, a later one past the hold time clears
        elapsed = now_ms_i - clear_begin_ms;
        if (!clear_pending) begin
          clear_pending = 1'b1;
          clear_begin_ms = now_ms_i;
        end else if (elapsed > 32'(cfg_regs[REG_HOLD])) begin
          stop_latched = 1'b0;
          clear_pending = 1'b0;
        end
      end else begin
        clear_pending = 1'b0;
        if (!stop_latched) begin
          if (b[BTN_START] && b[BTN_TRIANGLE]) stop_latched = 1'b1;
          else if (b[BTN_L1]) speed_sel = SPD_SLOW;
          else if (b[BTN_R1]) speed_sel = SPD_FAST;
          else if (b[BTN_L2]) speed_sel = SPD_MEDIUM;
          else speed_sel = SPD_DEFAULT;
        end
      end
      fwd_cmd = stick_cmd(left_stick_y_i, 1'b1);
      lat_cmd = stick_cmd(right_stick_x_i, 1'b0);
      trn_cmd = stick_cmd(left_stick_x_i, 1'b0);
      // d-pad overrides the sticks
      if (b[BTN_UP]) fwd_cmd = sat_cmd(CMD_ONE);
      else if (b[BTN_DOWN]) fwd_cmd = sat_cmd(-CMD_ONE);
      if (b[BTN_LEFT]) trn_cmd = sat_cmd(-CMD_ONE);
      else if (b[BTN_RIGHT]) trn_cmd = sat_cmd(CMD_ONE);
    end else begin
      // failed read: disconnect after the timeout
      elapsed = now_ms_i - last_good_ms;
      if (elapsed > 32'(cfg_regs[REG_DISC_TIMEOUT]) && link_up) begin
        link_up = 1'b0;
        stop_latched = 1'b1;
      end
    end
    r.fresh = read_ok_i;
    r.connected = link_up;
    r.estop_active = stop_latched;
    r.estop_clearing = clear_pending;
    r.forward_cmd = fwd_cmd;
    r.lateral_cmd = lat_cmd;
    r.turn_cmd = trn_cmd;
    case (speed_sel)
      SPD_SLOW:   r.speed_scale = cfg_regs[REG_SPD_SLOW];
      SPD_MEDIUM: r.speed_scale = cfg_regs[REG_SPD_MEDIUM];
      SPD_FAST:   r.speed_scale = cfg_regs[REG_SPD_FAST];
      default:    r.speed_scale = cfg_regs[REG_SPD_DEFAULT];
    endcase
    r.motor_active = above_creep(fwd_cmd) || above_creep(lat_cmd) || above_creep(trn_cmd);
    r.pressed_mask = pad_now & ~pad_prev;
    r.released_mask = pad_prev & ~pad_now;
    return r;
  endfunction

  function automatic int field_diff(input string label, input longint want, input longint got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    return 1;
  endfunction

  function automatic int count_diffs(input drive_report_t want);
    int n;
    n = field_diff("fresh", want.fresh, fresh_o);
    n += field_diff("connected", want.connected, connected_o);
    n += field_diff("estop_active", want.estop_active, estop_active_o);
    n += field_diff("estop_clearing", want.estop_clearing, estop_clearing_o);
    n += field_diff("forward_cmd", $signed(want.forward_cmd), forward_cmd_o);
    n += field_diff("lateral_cmd", $signed(want.lateral_cmd), lateral_cmd_o);
    n += field_diff("turn_cmd", $signed(want.turn_cmd), turn_cmd_o);
    n += field_diff("speed_scale", want.speed_scale, speed_scale_o);
    n += field_diff("motor_active", want.motor_active, motor_active_o);
    n += field_diff("pressed_mask", want.pressed_mask, pressed_mask_o);
    n += field_diff("released_mask", want.released_mask, released_mask_o);
    return n;
  endfunction

  // watch the three channels: register writes, results, then new polls
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    drive_report_t want;
    if (!rst_ni) begin
      cfg_regs[REG_DEADBAND]     = DEADBAND_RST;
      cfg_regs[REG_DISC_TIMEOUT] = DISC_TIMEOUT_RST;
      cfg_regs[REG_HOLD]         = HOLD_RST;
      cfg_regs[REG_SPD_DEFAULT]  = SPD_DEFAULT_RST;
      cfg_regs[REG_SPD_SLOW]     = SPD_SLOW_RST;
      cfg_regs[REG_SPD_MEDIUM]   = SPD_MEDIUM_RST;
      cfg_regs[REG_SPD_FAST]     = SPD_FAST_RST;
      link_up = 1'b0;
      stop_latched = 1'b0;
      clear_pending = 1'b0;
      last_good_ms = '0;
      clear_begin_ms = '0;
      pad_now = '0;
      pad_prev = '0;
      fwd_cmd = '0;
      lat_cmd = '0;
      trn_cmd = '0;
      speed_sel = SPD_DEFAULT;
      reports_due.delete();
      err_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o && cfg_index_i <= REG_SPD_FAST)
        cfg_regs[cfg_index_i] = cfg_data_i;
      if (out_valid_o && out_ready_i) begin
        if (reports_due.size() == 0) begin
          $display("%0t: result word mismatch, expected none, got one", $time);
          err_count++;
        end else begin
          want = reports_due.pop_front();
          err_count += count_diffs(want);
        end
      end
      if (in_valid_i && in_ready_o) reports_due.push_back(condition_poll());
    end
    mismatch_count_o <= err_count;
    pending_reports_o <= reports_due.size();
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none

module tb_top;
  import gdcc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 600;
  localparam int DRAIN_WAIT  = 120;

  localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam logic [15:0] PAD_SELECT   = 16'h1 << BTN_SELECT;
  localparam logic [15:0] PAD_START    = 16'h1 << BTN_START;
  localparam logic [15:0] PAD_UP       = 16'h1 << BTN_UP;
  localparam logic [15:0] PAD_RIGHT    = 16'h1 << BTN_RIGHT;
  localparam logic [15:0] PAD_DOWN     = 16'h1 << BTN_DOWN;
  localparam logic [15:0] PAD_LEFT     = 16'h1 << BTN_LEFT;
  localparam logic [15:0] PAD_L2       = 16'h1 << BTN_L2;
  localparam logic [15:0] PAD_L1       = 16'h1 << BTN_L1;
  localparam logic [15:0] PAD_R1       = 16'h1 << BTN_R1;
  localparam logic [15:0] PAD_TRIANGLE = 16'h1 << BTN_TRIANGLE;
  localparam logic [15:0] PAD_SHOULDERS = PAD_L1 | PAD_R1 | PAD_L2;
  localparam logic [15:0] PAD_DPAD = PAD_UP | PAD_DOWN | PAD_LEFT | PAD_RIGHT;
  localparam logic [15:0] PAD_NAMED = PAD_SHOULDERS | PAD_DPAD | PAD_SELECT | PAD_START
                                      | PAD_TRIANGLE;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0]          cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 read_ok_i = 1'b0;
  logic [15:0]          button_word_i = '0;
  logic [7:0]           left_stick_x_i = 8'd128;
  logic [7:0]           left_stick_y_i = 8'd128;
  logic [7:0]           right_stick_x_i = 8'd128;
  logic [31:0]          now_ms_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 fresh_o;
  logic                 connected_o;
  logic                 estop_active_o;
  logic                 estop_clearing_o;
  logic signed [15:0]   forward_cmd_o;
  logic signed [15:0]   lateral_cmd_o;
  logic signed [15:0]   turn_cmd_o;
  logic [15:0]          speed_scale_o;
  logic                 motor_active_o;
  logic [15:0]          pressed_mask_o;
  logic [15:0]          released_mask_o;

  int                   mismatch_count;
  int                   reports_pending;
  logic                 calm = 1'b0;
  logic                 long_hold_req = 1'b0;
  logic [31:0]          clock_ms = '0;
  logic [15:0]          reg_vals [7];

  gamepad_drive_command_conditioner_top uut (.*);

  drive_report_checker report_chk (
    .mismatch_count_o (mismatch_count),
    .pending_reports_o(reports_pending),
    .*
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: random stall bursts plus one long hold-off
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // end the run if no channel moves a word for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // offer one poll word, with an optional idle burst in front
  task automatic send_poll(input logic ok, input logic [15:0] btn, input logic [7:0] lx,
                           input logic [7:0] ly, input logic [7:0] rx,
                           input logic [31:0] now);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    read_ok_i <= ok;
    button_word_i <= btn;
    left_stick_x_i <= lx;
    left_stick_y_i <= ly;
    right_stick_x_i <= rx;
    now_ms_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    if (idx <= REG_SPD_FAST) reg_vals[idx] = val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_settings(input logic [15:0] dband, input logic [15:0] tmo,
                                input logic [15:0] hold, input logic [15:0] sdef,
                                input logic [15:0] sslow, input logic [15:0] smed,
                                input logic [15:0] sfast);
    write_reg(REG_DEADBAND, dband);
    write_reg(REG_DISC_TIMEOUT, tmo);
    write_reg(REG_HOLD, hold);
    write_reg(REG_SPD_DEFAULT, sdef);
    write_reg(REG_SPD_SLOW, sslow);
    write_reg(REG_SPD_MEDIUM, smed);
    write_reg(REG_SPD_FAST, sfast);
    // unused index, must leave the registers alone
    write_reg(REG_NONE, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering and wait until every result word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (reports_pending != 0) @(posedge clk_i);
  endtask

  // stick byte: centre, full throw, around the deadband rim, or anything
  function automatic logic [7:0] pick_stick();
    int rim;
    rim = (int'(reg_vals[REG_DEADBAND]) * 127) / 65536 + int'($urandom_range(0, 2)) - 1;
    if (rim < 0) rim = 0;
    if (rim > 127) rim = 127;
    case ($urandom_range(0, 7))
      0:       return 8'd128;
      1:       return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      2, 3:    return ($urandom_range(0, 1) != 0) ? 8'(128 + rim) : 8'(128 - rim);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly timed pad sequences: stop triggers, held clears, failed-read runs
  task automatic random_polls(input int count, input int unsigned step_max);
    int          streak;
    int          fails;
    logic        ok;
    logic [15:0] btn;
    streak = 0;
    fails = 0;
    for (int i = 0; i < count; i++) begin
      clock_ms += $urandom_range(0, step_max);
      if ($urandom_range(0, 24) == 0)
        clock_ms = ($urandom_range(0, 1) != 0) ? $urandom
                                                : 32'hFFFF_FFFF - $urandom_range(0, 3000);
      if (fails > 0) begin
        ok = 1'b0;
        fails--;
      end else begin
        ok = ($urandom_range(0, 9) < 8);
      end
      if (streak > 0) begin
        btn = PAD_SELECT | PAD_START;
        if ($urandom_range(0, 3) == 0) btn |= 16'($urandom) & (PAD_SHOULDERS | PAD_DPAD);
        streak--;
      end else begin
        case ($urandom_range(0, 11))
          0, 1: btn = '0;
          2:    btn = 16'($urandom);
          3:    btn = PAD_START | PAD_TRIANGLE;
          4: begin
            btn = PAD_SELECT | PAD_START;
            streak = $urandom_range(1, 8);
          end
          5:    btn = 16'($urandom) & PAD_SHOULDERS;
          6:    btn = 16'($urandom) & (PAD_DPAD | PAD_SHOULDERS);
          7: begin
            btn = 16'($urandom);
            fails = $urandom_range(1, 6);
          end
          default: btn = 16'($urandom) & PAD_NAMED;
        endcase
      end
      send_poll(ok, btn, pick_stick(), pick_stick(), pick_stick(), clock_ms);
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    reg_vals[REG_DEADBAND]     = DEADBAND_RST;
    reg_vals[REG_DISC_TIMEOUT] = DISC_TIMEOUT_RST;
    reg_vals[REG_HOLD]         = HOLD_RST;
    reg_vals[REG_SPD_DEFAULT]  = SPD_DEFAULT_RST;
    reg_vals[REG_SPD_SLOW]     = SPD_SLOW_RST;
    reg_vals[REG_SPD_MEDIUM]   = SPD_MEDIUM_RST;
    reg_vals[REG_SPD_FAST]     = SPD_FAST_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // stick extremes and both divisor sides
    send_poll(1'b1, 16'h0000, 8'd128, 8'd128, 8'd128, 32'd10);
    send_poll(1'b1, 16'h0000, 8'd0, 8'd255, 8'd128, 32'd20);
    send_poll(1'b1, 16'h0000, 8'd255, 8'd0, 8'd255, 32'd30);
    send_poll(1'b1, 16'h0000, 8'd127, 8'd129, 8'd0, 32'd40);
    // speed choice and its priority
    send_poll(1'b1, PAD_L1, 8'd140, 8'd100, 8'd200, 32'd50);
    send_poll(1'b1, PAD_R1, 8'd60, 8'd180, 8'd20, 32'd60);
    send_poll(1'b1, PAD_L2, 8'd150, 8'd150, 8'd110, 32'd70);
    send_poll(1'b1, PAD_SHOULDERS, 8'd128, 8'd128, 8'd128, 32'd80);
    // d-pad override, up and left win
    send_poll(1'b1, PAD_DPAD, 8'd0, 8'd0, 8'd0, 32'd90);
    send_poll(1'b1, PAD_DOWN | PAD_RIGHT, 8'd255, 8'd255, 8'd255, 32'd100);
    // stop trigger, speed frozen, held clear
    send_poll(1'b1, PAD_START | PAD_TRIANGLE, 8'd128, 8'd128, 8'd128, 32'd110);
    send_poll(1'b1, PAD_L1, 8'd128, 8'd128, 8'd128, 32'd120);
    send_poll(1'b1, PAD_SELECT | PAD_START, 8'd128, 8'd128, 8'd128, 32'd200);
    send_poll(1'b1, PAD_SELECT | PAD_START, 8'd128, 8'd128, 8'd128, 32'd700);
    send_poll(1'b1, PAD_SELECT | PAD_START, 8'd128, 8'd128, 8'd128, 32'd1201);
    // failed reads: inside the timeout, then past it
    send_poll(1'b1, 16'h0000, 8'd128, 8'd128, 8'd128, 32'd1210);
    send_poll(1'b0, 16'hFFFF, 8'd255, 8'd0, 8'd255, 32'd1290);
    send_poll(1'b0, 16'h0000, 8'd0, 8'd0, 8'd0, 32'd1311);
    // clear hold survives a disconnect
    send_poll(1'b1, PAD_SELECT | PAD_START, 8'd128, 8'd128, 8'd128, 32'd1400);
    send_poll(1'b0, 16'h0000, 8'd128, 8'd128, 8'd128, 32'd3000);
    send_poll(1'b1, PAD_SELECT | PAD_START, 8'd128, 8'd128, 8'd128, 32'd3010);
    send_poll(1'b1, PAD_SELECT | PAD_START | PAD_TRIANGLE, 8'd128, 8'd128, 8'd128, 32'd3020);
    // hold that spans the timestamp wrap
    send_poll(1'b1, 16'hFFFF, 8'd3, 8'd250, 8'd129, 32'hFFFF_FFF0);
    send_poll(1'b1, PAD_SELECT | PAD_START, 8'd128, 8'd128, 8'd128, 32'h0000_0400);
    send_poll(1'b1, 16'h0000, 8'd128, 8'd128, 8'd128, 32'h0000_0410);
    clock_ms = 32'h0000_0410;

    // reset settings, with the long result hold-off
    random_polls(40, 400);
    long_hold_req = 1'b1;
    random_polls(130, 400);

    // zero deadband, timeout and hold
    drain();
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd1, 16'h8000);
    random_polls(170, 3);

    // deadband, timeout, hold and default speed at full scale
    drain();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd12345, 16'd1);
    random_polls(170, 40000);

    // short timeout and hold
    drain();
    apply_settings(16'($urandom), 16'($urandom_range(10, 300)), 16'($urandom_range(10, 600)),
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_polls(170, 300);

    // moderate deadband, last stretch without idling
    drain();
    apply_settings(16'($urandom_range(0, 13107)), 16'($urandom_range(50, 400)),
                   16'($urandom_range(100, 1500)), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
    random_polls(90, 500);
    calm = 1'b1;
    random_polls(80, 500);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
